### sv/mtg_pkg.sv
// Package for the MT19937 word generator: constants, sequencer states,
// feedback control struct and the tempering function.
// No dependencies; every other file but the checker uses it.
`default_nettype none

package mtg_pkg;

  localparam int unsigned WORD_W            = 32;
  localparam int unsigned STATE_WORDS_DEF   = 624;
  localparam int unsigned MIDDLE_OFFSET_DEF = 397;

  localparam logic [WORD_W-1:0] TWIST_XOR     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] HIGH_BIT_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOW_BITS_MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B      = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C      = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT     = 32'd1812433253;
  localparam logic [WORD_W-1:0] RESET_SEED    = 32'd5489;

  // Sequencer: serve draws, run the seeding pass, draw the pending word
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FILL,
    ST_DRAW
  } mtg_state_t;

  // Control from the sequencer to the feedback unit
  typedef struct packed {
    logic fill;   // push seed recurrence instead of twisted word
    logic first;  // first word of the seeding pass is the seed itself
  } mtg_fb_ctrl_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

### sv/mtg_channels.sv
// Handshake channel interfaces of the MT19937 generator: draw requests,
// output words and seed writes. Depends on mtg_pkg for the word width.
`default_nettype none

interface mtg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mtg_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtg_pkg::WORD_W-1:0] random_word;
  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

interface mtg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mtg_pkg::WORD_W-1:0] seed_value;
  modport source (output valid, output seed_value, input ready);
  modport sink   (input valid, input seed_value, output ready);
endinterface

`default_nettype wire

### sv/mtg_cell.sv
// One state cell of the generator: a 32-bit word that takes its
// input word on every shift. Depends on mtg_pkg.
`default_nettype none

module mtg_cell (
  input  wire logic                       clk,
  input  wire logic                       shift_en,
  input  wire logic [mtg_pkg::WORD_W-1:0] d_in,
  output logic      [mtg_pkg::WORD_W-1:0] q_out
);
  import mtg_pkg::*;

  logic [WORD_W-1:0] word_r;

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d_in;
    end
  end

  assign q_out = word_r;

endmodule

`default_nettype wire

### sv/mtg_feedback.sv
// Feedback word for the cell chain: either the MT19937 twist of the
// oldest, second and middle words, or the seed itself or the next
// word of the seed recurrence. Depends on mtg_pkg.
`default_nettype none

module mtg_feedback #(
  parameter int unsigned CNT_W = 10
) (
  input  wire logic                       [mtg_pkg::WORD_W-1:0] oldest,
  input  wire logic                       [mtg_pkg::WORD_W-1:0] second,
  input  wire logic                       [mtg_pkg::WORD_W-1:0] middle,
  input  wire logic                       [mtg_pkg::WORD_W-1:0] newest,
  input  wire logic                       [mtg_pkg::WORD_W-1:0] seed,
  input  wire logic                       [CNT_W-1:0]           fill_idx,
  input  wire mtg_pkg::mtg_fb_ctrl_t                            ctrl,
  output logic                            [mtg_pkg::WORD_W-1:0] next_word
);
  import mtg_pkg::*;

  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] twisted;
  logic [WORD_W-1:0] seeded;

  // twist: upper bit of oldest, lower bits of its neighbor
  always_comb begin
    mix     = (oldest & HIGH_BIT_MASK) | (second & LOW_BITS_MASK);
    twisted = middle ^ (mix >> 1);
    if (mix[0]) begin
      twisted = twisted ^ TWIST_XOR;
    end
  end

  // seed recurrence, low 32 bits of the product
  always_comb begin
    seeded = SEED_MULT * (newest ^ (newest >> 30));
    seeded = seeded + WORD_W'(fill_idx);
  end

  always_comb begin
    priority if (ctrl.fill && ctrl.first) begin
      next_word = seed;
    end else if (ctrl.fill) begin
      next_word = seeded;
    end else begin
      next_word = twisted;
    end
  end

endmodule

`default_nettype wire

### sv/mtg_outreg.sv
// Output stage: tempers the drawn word and holds it until the receiver
// takes it. Depends on mtg_pkg and mtg_channels.
`default_nettype none

module mtg_outreg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       load,
  input  wire logic [mtg_pkg::WORD_W-1:0] raw_word,
  output logic                            slot_free,
  mtg_out_if.source                       out_ch
);
  import mtg_pkg::*;

  logic              valid_r;
  logic              valid_nxt;
  logic [WORD_W-1:0] word_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_comb begin
    priority if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= temper(raw_word);
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.random_word = word_r;

endmodule

`default_nettype wire

### sv/mersenne_twister_generator.sv
// MT19937 pseudo-random word generator, top level.
// Channels: in_ch carries draw requests (restart bit), out_ch returns one
// tempered 32-bit word per request, cfg_ch writes the seed register.
// The state is a chain of STATE_WORDS cells that shifts by one word per
// draw; the feedback unit forms the twisted word from the oldest, second
// and middle cells and pushes it into the newest cell, so the twist runs
// one word per clock alongside the output while draws do not stall.
// Throughput: one word per cycle while seeded and the receiver keeps up;
// a taken request's word is valid in the cycle after it is taken.
// A request that finds the generator unseeded, or carries restart, first
// runs the seeding pass, which pushes the seed and then the recurrence
// words into the chain, one recurrence step (one 32x32 multiply) per
// cycle; then the draw state draws the word once the output slot is free.
// No request is taken meanwhile.
// Reset: seed register back to 5489, generator unseeded, no output held.
// A seed write also leaves the generator unseeded; it is always ready.
// Stall: the tempered word waits in the output register; a new request
// is taken in the cycle the waiting word leaves.
// Depends on mtg_pkg, mtg_channels, mtg_cell, mtg_feedback, mtg_outreg.
`default_nettype none

module mersenne_twister_generator #(
  parameter int unsigned STATE_WORDS   = mtg_pkg::STATE_WORDS_DEF,
  parameter int unsigned MIDDLE_OFFSET = mtg_pkg::MIDDLE_OFFSET_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mtg_in_if.sink     in_ch,
  mtg_out_if.source  out_ch,
  mtg_cfg_if.sink    cfg_ch
);
  import mtg_pkg::*;

  localparam int unsigned CNT_W = $clog2(STATE_WORDS);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(STATE_WORDS - 1);

  mtg_state_t        state_r;
  mtg_state_t        state_nxt;
  logic [CNT_W-1:0]  fill_cnt_r;
  logic [CNT_W-1:0]  fill_cnt_nxt;
  logic              seeded_r;
  logic              seeded_nxt;
  logic [WORD_W-1:0] seed_r;

  logic              slot_free;
  logic              in_acc;
  logic              need_fill;
  logic              shift_en;
  logic              draw;
  logic              fill_last;
  mtg_fb_ctrl_t      fb_ctrl;
  logic [WORD_W-1:0] feed_word;
  logic [WORD_W-1:0] cell_q [STATE_WORDS];

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign need_fill = in_ch.restart || !seeded_r;
  assign fill_last = (fill_cnt_r == LAST_IDX);
  assign cfg_ch.ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_acc && need_fill) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          state_nxt = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (slot_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    shift_en    = 1'b0;
    draw        = 1'b0;
    fb_ctrl     = '0;
    unique case (state_r)
      ST_RUN: begin
        in_ch.ready = slot_free;
        draw        = in_ch.valid && slot_free && !need_fill;
        shift_en    = draw;
      end
      ST_FILL: begin
        shift_en      = 1'b1;
        fb_ctrl.fill  = 1'b1;
        fb_ctrl.first = (fill_cnt_r == '0);
      end
      ST_DRAW: begin
        draw     = slot_free;
        shift_en = slot_free;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // seeding pass counter and seeded flag
  always_comb begin
    fill_cnt_nxt = '0;
    if (state_r == ST_FILL && !fill_last) begin
      fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
    end
    seeded_nxt = seeded_r;
    priority if (cfg_ch.valid) begin
      seeded_nxt = 1'b0;
    end else if (state_r == ST_FILL && fill_last) begin
      seeded_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      fill_cnt_r <= '0;
      seeded_r   <= 1'b0;
      seed_r     <= RESET_SEED;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      seeded_r   <= seeded_nxt;
      if (cfg_ch.valid) begin
        seed_r <= cfg_ch.seed_value;
      end
    end
  end

  // cell chain: cell 0 is the oldest word, the last cell takes feedback
  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
    if (k == STATE_WORDS - 1) begin : g_tail
      mtg_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (feed_word),
        .q_out    (cell_q[k])
      );
    end else begin : g_body
      mtg_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d_in     (cell_q[k+1]),
        .q_out    (cell_q[k])
      );
    end
  end

  mtg_feedback #(
    .CNT_W (CNT_W)
  ) u_feedback (
    .oldest    (cell_q[0]),
    .second    (cell_q[1]),
    .middle    (cell_q[MIDDLE_OFFSET]),
    .newest    (cell_q[STATE_WORDS-1]),
    .seed      (seed_r),
    .fill_idx  (fill_cnt_r),
    .ctrl      (fb_ctrl),
    .next_word (feed_word)
  );

  mtg_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (draw),
    .raw_word  (feed_word),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### sv/mtg_checker.sv
// Port-level checker for the MT19937 generator and its bind to the top
// level. Depends only on the top level's ports.
`default_nettype none

module mtg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_word
);

  logic in_acc;
  logic out_acc;
  logic pending_r;
  logic pending_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken but not yet delivered: never more than one
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc && !out_acc) begin
      pending_nxt = 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // a word is only shown for a request that was taken
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r)
    else $error("output word without an outstanding request");

  // no second request while one is outstanding and not leaving
  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r && !out_acc) |-> !in_ready)
    else $error("request taken while another is outstanding");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_word))
    else $error("output word changed while stalled");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.random_word)
);

`default_nettype wire

### verif/mersenne_twister_generator_tb.sv
// Testbench for mersenne_twister_generator: random draw requests and seed
// writes, each returned word checked against a behavioral MT19937 predictor.
// Depends on mtg_pkg, mtg_channels and the generator RTL.

module mersenne_twister_generator_tb;
  import mtg_pkg::*;

  localparam int unsigned UNSEEDED_INDEX = STATE_WORDS_DEF + 1;
  localparam int          TIMEOUT_UNITS  = 1_600_000;
  localparam int          MAX_REPORTS    = 10;

  logic clk;
  logic rst_n;

  mtg_in_if  in_ch();
  mtg_out_if out_ch();
  mtg_cfg_if cfg_ch();

  mersenne_twister_generator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: twister words, draw position and seed register copy
  logic [WORD_W-1:0] mt_state [0:STATE_WORDS_DEF-1];
  int unsigned       mt_index    = UNSEEDED_INDEX;
  logic [WORD_W-1:0] seed_shadow = RESET_SEED;

  logic              pending_restarts [$];
  logic [WORD_W-1:0] expected_words [$];
  int                mismatch_count = 0;

  // Request side and word side idle bookkeeping
  int draw_gap  = 0;
  int draw_run  = 0;
  int word_hold = 0;
  int word_run  = 0;

  // Word for one accepted request; refills and twists the state as needed
  function automatic logic [WORD_W-1:0] next_random_word(input logic restart);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] prev;
    int unsigned       k;
    if (restart || mt_index == UNSEEDED_INDEX) begin
      mt_state[0] = seed_shadow;
      for (k = 1; k < STATE_WORDS_DEF; k++) begin
        prev = mt_state[k-1];
        mt_state[k] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(k);
      end
      mt_index = STATE_WORDS_DEF;
    end
    if (mt_index >= STATE_WORDS_DEF) begin
      for (k = 0; k < STATE_WORDS_DEF; k++) begin
        y = (mt_state[k] & HIGH_BIT_MASK) |
            (mt_state[(k + 1) % STATE_WORDS_DEF] & LOW_BITS_MASK);
        v = mt_state[(k + MIDDLE_OFFSET_DEF) % STATE_WORDS_DEF] ^ (y >> 1);
        if (y[0]) v = v ^ TWIST_XOR;
        mt_state[k] = v;
      end
      mt_index = 0;
    end
    y = mt_state[mt_index];
    mt_index++;
    // tempering
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Idle length: mostly none or short, a few long, with idle-free stretches
  function automatic int idle_len(inout int run_left);
    int r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      run_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Clock and known input values from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.seed_value = RESET_SEED;
    forever #1 clk = ~clk;
  end

  // Request driver: predicts on acceptance, then pulls the next request
  always @(posedge clk) begin
    logic nxt_valid;
    logic nxt_restart;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.restart <= 1'b0;
    end else begin
      nxt_valid = in_ch.valid;
      nxt_restart = in_ch.restart;
      if (in_ch.valid && in_ch.ready) begin
        expected_words.push_back(next_random_word(in_ch.restart));
        nxt_valid = 1'b0;
        draw_gap = idle_len(draw_run);
      end
      if (!nxt_valid) begin
        if (draw_gap > 0) begin
          draw_gap--;
        end else if (pending_restarts.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_restart = pending_restarts.pop_front();
        end
      end
      in_ch.valid <= nxt_valid;
      in_ch.restart <= nxt_restart;
    end
  end

  // Word monitor: compare against the oldest expected word, random stalls
  always @(posedge clk) begin
    logic [WORD_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("word %08h returned with no request pending", out_ch.random_word);
        end else begin
          want = expected_words.pop_front();
          if (out_ch.random_word !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("random_word mismatch: expected %08h, got %08h",
                       want, out_ch.random_word);
          end
        end
        word_hold = idle_len(word_run);
      end
      if (word_hold > 0) begin
        word_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Wait until every queued request is taken and every word has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_restarts.size() != 0 || in_ch.valid || expected_words.size() != 0);
  endtask

  // Seed write on an idle generator; predictor becomes unseeded
  task automatic write_seed(input logic [WORD_W-1:0] seed);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed_value <= seed;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    seed_shadow = seed;
    mt_index = UNSEEDED_INDEX;
    @(negedge clk);
  endtask

  task automatic queue_draws(input int count, input int restart_pct);
    repeat (count) pending_restarts.push_back($urandom_range(0, 99) < restart_pct);
  endtask

  // Stimulus: directed corners, one long run past the twist, short phases
  initial begin
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset seed: unseeded first draw, then a restart on a seeded generator
    queue_draws(4, 0);
    pending_restarts.push_back(1'b1);
    queue_draws(2, 0);
    wait_idle();

    // restart as the first request after a seed write
    write_seed('0);
    pending_restarts.push_back(1'b1);
    queue_draws(2, 0);
    wait_idle();

    write_seed('1);
    queue_draws(3, 0);
    pending_restarts.push_back(1'b1);
    queue_draws(1, 0);
    wait_idle();

    write_seed(RESET_SEED);
    queue_draws(2, 0);
    wait_idle();

    // long run: wraps past the full state once before a restart
    write_seed(pick_seed());
    for (i = 0; i < 700; i++) pending_restarts.push_back(i == 660);
    wait_idle();

    // short phases with random seeds and frequent restarts
    repeat (6) begin
      write_seed(pick_seed());
      queue_draws($urandom_range(10, 20), 15);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT_UNITS;
    $display("TB_ERROR");
    $finish;
  end

endmodule
